FILE: design/prc_pkg.sv
// shared types, codes and helpers for the peer notify retry controller
package prc_pkg;

    localparam int TIME_W  = 26;
    localparam int RETRY_W = 4;
    localparam int CODE_W  = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [TIME_W-1:0]  STARTUP_WAIT_RST      = TIME_W'(1000 * 1000);
    localparam logic [TIME_W-1:0]  FIRST_SEARCH_WAIT_RST = TIME_W'(1000 * 1000);
    localparam logic [TIME_W-1:0]  SEARCH_PERIOD_RST     = TIME_W'(5000 * 1000);
    localparam logic [TIME_W-1:0]  RESPONSE_WAIT_RST     = TIME_W'(1000 * 1000);
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST       = 4'd3;

    localparam logic [CODE_W-1:0] CODE_NOTIFY = 8'hB1;
    localparam logic [CODE_W-1:0] CODE_SEARCH = 8'hD6;

    localparam logic [1:0] KIND_TIME     = 2'd0;
    localparam logic [1:0] KIND_PROPERTY = 2'd1;
    localparam logic [1:0] KIND_WAKE     = 2'd2;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_SEARCH = 3'd2;
    localparam logic [2:0] ACT_NOTIFY = 3'd3;
    localparam logic [2:0] ACT_FAULT  = 3'd4;

    localparam logic [1:0] PHASE_CODE_START  = 2'd0;
    localparam logic [1:0] PHASE_CODE_IDLE   = 2'd1;
    localparam logic [1:0] PHASE_CODE_SEARCH = 2'd2;
    localparam logic [1:0] PHASE_CODE_WAIT   = 2'd3;

    localparam logic [2:0] REG_STARTUP_WAIT      = 3'd0;
    localparam logic [2:0] REG_FIRST_SEARCH_WAIT = 3'd1;
    localparam logic [2:0] REG_SEARCH_PERIOD     = 3'd2;
    localparam logic [2:0] REG_RESPONSE_WAIT     = 3'd3;
    localparam logic [2:0] REG_RETRY_LIMIT       = 3'd4;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_IDLE   = 4'b0010,
        PH_SEARCH = 4'b0100,
        PH_WAIT   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] elapsed_us;
        logic [CODE_W-1:0] property_code;
        logic              is_notify_response;
        logic              from_peer;
        logic [CODE_W-1:0] wake_code;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [1:0]         phase;
        logic               timer_armed;
        logic [TIME_W-1:0]  time_left_us;
        logic [RETRY_W-1:0] retries_left;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0]  startup_wait_us;
        logic [TIME_W-1:0]  first_search_wait_us;
        logic [TIME_W-1:0]  search_period_us;
        logic [TIME_W-1:0]  response_wait_us;
        logic [RETRY_W-1:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [TIME_W-1:0]  timer_count;
        logic               timer_on;
        logic [RETRY_W-1:0] retry_count;
    } state_t;

    // zero wait counts as one microsecond
    function automatic logic [TIME_W-1:0] wait_value(input logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

    function automatic logic [1:0] phase_code(input phase_t p);
        logic [1:0] c;
        unique case (p)
            PH_START:  c = PHASE_CODE_START;
            PH_IDLE:   c = PHASE_CODE_IDLE;
            PH_SEARCH: c = PHASE_CODE_SEARCH;
            PH_WAIT:   c = PHASE_CODE_WAIT;
            default:   c = PHASE_CODE_START;
        endcase
        return c;
    endfunction

endpackage

FILE: design/prc_regs.sv
// configuration register file with apb-style access
module prc_regs
    import prc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [2:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_STARTUP_WAIT:      cfg_next.startup_wait_us      = pwdata[TIME_W-1:0];
                REG_FIRST_SEARCH_WAIT: cfg_next.first_search_wait_us = pwdata[TIME_W-1:0];
                REG_SEARCH_PERIOD:     cfg_next.search_period_us     = pwdata[TIME_W-1:0];
                REG_RESPONSE_WAIT:     cfg_next.response_wait_us     = pwdata[TIME_W-1:0];
                REG_RETRY_LIMIT:       cfg_next.retry_limit          = pwdata[RETRY_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_STARTUP_WAIT:      prdata = DATA_W'(cfg_reg.startup_wait_us);
            REG_FIRST_SEARCH_WAIT: prdata = DATA_W'(cfg_reg.first_search_wait_us);
            REG_SEARCH_PERIOD:     prdata = DATA_W'(cfg_reg.search_period_us);
            REG_RESPONSE_WAIT:     prdata = DATA_W'(cfg_reg.response_wait_us);
            REG_RETRY_LIMIT:       prdata = DATA_W'(cfg_reg.retry_limit);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_wait_us      <= STARTUP_WAIT_RST;
            cfg_reg.first_search_wait_us <= FIRST_SEARCH_WAIT_RST;
            cfg_reg.search_period_us     <= SEARCH_PERIOD_RST;
            cfg_reg.response_wait_us     <= RESPONSE_WAIT_RST;
            cfg_reg.retry_limit          <= RETRY_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/prc_step.sv
// next-state and result logic for one request
module prc_step
    import prc_pkg::*;
(
    input  state_t state,
    input  cfg_t   cfg,
    input  cmd_t   cmd,
    output state_t state_next,
    output rsp_t   rsp
);

    logic [TIME_W-1:0] count_dec;
    state_t            s;
    logic [2:0]        act;

    assign count_dec = (cmd.elapsed_us >= state.timer_count) ? '0
                     : state.timer_count - cmd.elapsed_us;

    always_comb
    begin
        s   = state;
        act = ACT_NONE;

        // count down
        if (state.timer_on)
        begin
            s.timer_count = count_dec;
        end

        // event
        case (cmd.kind)
            KIND_PROPERTY:
            begin
                if (cmd.property_code == CODE_NOTIFY && s.phase == PH_WAIT
                    && cmd.is_notify_response && cmd.from_peer)
                begin
                    s.phase       = PH_IDLE;
                    s.timer_count = '0;
                    s.timer_on    = 1'b0;
                end
                else if (cmd.property_code == CODE_SEARCH && s.phase == PH_SEARCH
                         && cmd.from_peer)
                begin
                    s.phase       = PH_IDLE;
                    s.timer_count = '0;
                    s.timer_on    = 1'b0;
                end
            end
            KIND_WAKE:
            begin
                if (cmd.wake_code == CODE_NOTIFY
                    && (s.phase == PH_IDLE || s.phase == PH_WAIT))
                begin
                    act           = ACT_NOTIFY;
                    s.phase       = PH_WAIT;
                    s.timer_count = wait_value(cfg.response_wait_us);
                    s.timer_on    = 1'b1;
                    s.retry_count = cfg.retry_limit;
                end
            end
            default:
            begin
            end
        endcase

        // expiry
        if (s.timer_on && s.timer_count == '0)
        begin
            unique case (s.phase)
                PH_START:
                begin
                    act           = ACT_START;
                    s.phase       = PH_SEARCH;
                    s.timer_count = wait_value(cfg.first_search_wait_us);
                end
                PH_IDLE:
                begin
                    act        = ACT_FAULT;
                    s.timer_on = 1'b0;
                end
                PH_SEARCH:
                begin
                    act           = ACT_SEARCH;
                    s.timer_count = wait_value(cfg.search_period_us);
                end
                PH_WAIT:
                begin
                    if (s.retry_count == '0)
                    begin
                        s.phase    = PH_IDLE;
                        s.timer_on = 1'b0;
                    end
                    else
                    begin
                        act           = ACT_NOTIFY;
                        s.timer_count = wait_value(cfg.response_wait_us);
                        s.retry_count = s.retry_count - RETRY_W'(1);
                    end
                end
                default:
                begin
                    s.phase    = PH_START;
                    s.timer_on = 1'b0;
                end
            endcase
        end
    end

    assign state_next       = s;
    assign rsp.action       = act;
    assign rsp.phase        = phase_code(s.phase);
    assign rsp.timer_armed  = s.timer_on;
    assign rsp.time_left_us = s.timer_on ? s.timer_count : '0;
    assign rsp.retries_left = s.retry_count;

endmodule

FILE: design/peer_notify_retry_controller_core.sv
// top level of the peer notify retry controller
//
// requests arrive on cmd (cmd_valid / cmd_stall), one result per request
// leaves on rsp (rsp_valid / rsp_stall); a transfer happens when valid is
// high and stall is low
// a request is captured in an input register, evaluated against the
// controller state and written to the result register
// the result register drives rsp and rsp_valid
// throughput: one request per cycle while rsp_stall is low
// while the result register holds an untaken result, one more request
// waits in the input register; cmd_stall rises only when both are full
// the apb-style port writes timing and retry registers; pready is always high
// reset clears both valid flags, loads register defaults and puts the
// controller in the start phase with the startup timer armed
module peer_notify_retry_controller_core
    import prc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t   cfg;
    logic   cmd_valid_reg;
    cmd_t   cmd_data_reg;
    logic   rsp_valid_reg;
    rsp_t   rsp_data_reg;
    state_t state_reg;
    state_t state_next;
    rsp_t   rsp_next;
    logic   advance;
    logic   cmd_take;

    prc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prc_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .cmd        (cmd_data_reg),
        .state_next (state_next),
        .rsp        (rsp_next)
    );

    assign advance   = cmd_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = cmd_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg         <= 1'b0;
            rsp_valid_reg         <= 1'b0;
            state_reg.phase       <= PH_START;
            state_reg.timer_count <= wait_value(STARTUP_WAIT_RST);
            state_reg.timer_on    <= 1'b1;
            state_reg.retry_count <= '0;
        end
        else
        begin
            if (cmd_take)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                cmd_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_data_reg <= cmd;
        end
        if (advance)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

endmodule
